// File: hdl/bda_pkg.sv
// shared types and constants for the binary to decimal ascii converter
`timescale 1ns / 1ps

package bda_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ASCII_NINE = CHAR_W'(57);
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = DIGIT_W'(3);

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    // one queued item as the front classified it
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  is_zero;
    } t_q_item;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_EMIT
    } t_bk_state;

endpackage

// File: hdl/bda_front.sv
// front queue: accepts values, flags zero, holds them for the converter
`timescale 1ns / 1ps

module bda_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bda_pkg::VALUE_BITS-1:0] i_value,
    output bda_pkg::t_q_item              o_item,
    output logic                          o_q_valid,
    input  logic                          i_q_pop
);

    bda_pkg::t_q_item                  r_mem [bda_pkg::Q_DEPTH];
    logic [bda_pkg::Q_PTR_W-1:0]       r_wr_ptr;
    logic [bda_pkg::Q_PTR_W-1:0]       r_rd_ptr;
    logic [bda_pkg::Q_CNT_W-1:0]       r_count;
    logic [bda_pkg::Q_PTR_W-1:0]       n_wr_ptr;
    logic [bda_pkg::Q_PTR_W-1:0]       n_rd_ptr;
    logic [bda_pkg::Q_CNT_W-1:0]       n_count;
    logic                              do_push;
    logic                              do_pop;

    assign full      = (r_count == bda_pkg::Q_CNT_W'(bda_pkg::Q_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_item    = r_mem[r_rd_ptr];
    assign do_push   = push && !full;
    assign do_pop    = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == bda_pkg::Q_PTR_W'(bda_pkg::Q_DEPTH - 1))
                     ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == bda_pkg::Q_PTR_W'(bda_pkg::Q_DEPTH - 1))
                     ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr].value   <= i_value;
            r_mem[r_wr_ptr].is_zero <= (i_value == '0);
        end
    end

endmodule

// File: hdl/bda_back.sv
// back end: bit-serial double dabble and most-significant-first digit emitter
`timescale 1ns / 1ps

module bda_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bda_pkg::t_q_item              i_item,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [bda_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                          o_last
);

    bda_pkg::t_bk_state                r_state;
    bda_pkg::t_bk_state                n_state;
    logic [bda_pkg::VALUE_BITS-1:0]    r_bin;
    logic [bda_pkg::VALUE_BITS-1:0]    n_bin;
    bda_pkg::t_bcd                     r_bcd;
    bda_pkg::t_bcd                     n_bcd;
    bda_pkg::t_bcd                     bcd_adj;
    logic [bda_pkg::CNT_W-1:0]         r_cnt;
    logic [bda_pkg::CNT_W-1:0]         n_cnt;
    logic [bda_pkg::IDX_W-1:0]         r_idx;
    logic [bda_pkg::IDX_W-1:0]         n_idx;
    logic                              r_started;
    logic                              n_started;
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic [bda_pkg::CHAR_W-1:0]        r_out_char;
    logic [bda_pkg::CHAR_W-1:0]        n_out_char;
    logic                              r_out_last;
    logic                              n_out_last;
    logic [bda_pkg::DIGIT_W-1:0]       cur_digit;
    logic                              conv_done;
    logic                              skip;
    logic                              slot_free;
    logic                              load_out;

    assign cur_digit = r_bcd[r_idx];
    assign conv_done = (r_cnt == bda_pkg::CNT_W'(bda_pkg::VALUE_BITS - 1));
    assign skip      = !r_started && (cur_digit == '0) && (r_idx != '0);
    assign slot_free = !r_out_valid || pop;
    assign load_out  = (r_state == bda_pkg::BK_EMIT) && !skip && slot_free;

    always_comb begin
        for (int d = 0; d < bda_pkg::MAX_DIGITS; d++) begin
            bcd_adj[d] = (r_bcd[d] >= bda_pkg::BCD_ADJ_MIN)
                       ? r_bcd[d] + bda_pkg::BCD_ADJ_ADD : r_bcd[d];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bda_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_item.is_zero ? bda_pkg::BK_EMIT : bda_pkg::BK_CONV;
                end
            end
            bda_pkg::BK_CONV: begin
                if (conv_done) begin
                    n_state = bda_pkg::BK_EMIT;
                end
            end
            bda_pkg::BK_EMIT: begin
                if (load_out && (r_idx == '0)) begin
                    n_state = bda_pkg::BK_IDLE;
                end
            end
            default: n_state = bda_pkg::BK_IDLE;
        endcase
    end

    // datapath and handshake outputs
    always_comb begin
        o_q_pop     = 1'b0;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_started   = r_started;
        n_out_valid = r_out_valid && !pop;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        unique case (r_state)
            bda_pkg::BK_IDLE: begin
                o_q_pop   = i_q_valid;
                n_bin     = i_item.value;
                n_bcd     = '0;
                n_cnt     = '0;
                n_idx     = '0;
                n_started = 1'b0;
            end
            bda_pkg::BK_CONV: begin
                {n_bcd, n_bin} = {bcd_adj, r_bin} << 1;
                n_cnt          = r_cnt + 1'b1;
                n_idx          = bda_pkg::IDX_W'(bda_pkg::MAX_DIGITS - 1);
            end
            bda_pkg::BK_EMIT: begin
                if (skip) begin
                    n_idx = r_idx - 1'b1;
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = bda_pkg::ASCII_ZERO
                                + {{(bda_pkg::CHAR_W - bda_pkg::DIGIT_W){1'b0}}, cur_digit};
                    n_out_last  = (r_idx == '0);
                    n_started   = 1'b1;
                    if (r_idx != '0) begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bda_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_started   <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign empty        = !r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last       = r_out_last;

    // a waiting character is always a decimal digit
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_char >= bda_pkg::ASCII_ZERO)
                     && (r_out_char <= bda_pkg::ASCII_NINE))
        else $error("output character outside 0-9");

    // conversion runs without a break until every input bit is shifted in
    a_conv_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bda_pkg::BK_CONV) && !conv_done |=> (r_state == bda_pkg::BK_CONV))
        else $error("conversion left early");

    // the last digit ends the run and frees the converter
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && (r_idx == '0) |=> (r_state == bda_pkg::BK_IDLE) && r_out_last)
        else $error("final digit did not close the run");

    // the queue is only drained while idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == bda_pkg::BK_IDLE) && i_q_valid)
        else $error("queue popped outside idle");

endmodule

// File: hdl/binary_to_decimal_ascii_core.sv
// top level of the binary to decimal ascii converter
`timescale 1ns / 1ps

// converts each unsigned 32-bit value pushed in to its decimal text, one ascii
// digit per result transaction, most significant digit first and with no
// leading zeros; zero gives the single character '0', and o_last marks the
// final (least significant) digit of each number. a two-entry queue takes
// values while an earlier number is still converting. a nonzero value is
// picked from the queue in the idle state, then runs through bit-serial
// double dabble (one input bit per cycle through ten bcd digits), then the
// digits are walked from the top, where leading zeros are skipped and every
// other digit goes out through a one-deep output register. a zero value
// skips the shifting. a stalled pop holds the digit walk.

module binary_to_decimal_ascii_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input transactions
    input  logic                           push,
    output logic                           full,
    input  logic [bda_pkg::VALUE_BITS-1:0] i_value,
    // result transactions
    output logic                           empty,
    input  logic                           pop,
    output logic [bda_pkg::CHAR_W-1:0]     o_digit_char,
    output logic                           o_last
);

    // queued item and handshake between front and back
    bda_pkg::t_q_item q_item;
    logic             q_valid;
    logic             q_pop;

    // front: accept values and flag zero so the back can skip shifting
    bda_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_value   (i_value),
        .o_item    (q_item),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop)
    );

    // back: double dabble then digit emission
    bda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule

// File: sim/tb.sv
// testbench for the binary to decimal ascii converter
`timescale 1ns / 1ps

module tb;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 260;
    localparam int MAX_GAP      = 18;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_CYCLES = 100;

    localparam logic [bda_pkg::VALUE_BITS-1:0] DECIMAL_BASE = bda_pkg::VALUE_BITS'(10);

    // one digit transaction as it leaves the block
    typedef struct packed {
        logic [bda_pkg::CHAR_W-1:0] digit_char;
        logic                       is_last;
    } t_digit_txn;

    // directed row: value plus its decimal text where it is obvious, else blank
    typedef struct {
        logic [bda_pkg::VALUE_BITS-1:0] value;
        string                          text;
    } t_number_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    logic [bda_pkg::VALUE_BITS-1:0] i_value;
    logic                           empty;
    logic                           pop;
    logic [bda_pkg::CHAR_W-1:0]     o_digit_char;
    logic                           o_last;

    // digits still owed by the block, oldest first
    t_digit_txn pending_digits[$];
    int         mismatch_count = 0;
    int         digits_received = 0;

    // directed part: zero, single digits, powers of ten and their neighbors,
    // the full-scale value, alternating bit patterns and zero back to back
    t_number_row number_rows[] = '{
        '{32'd0,          "0"},
        '{32'd1,          "1"},
        '{32'd9,          "9"},
        '{32'd10,         ""},
        '{32'd99,         ""},
        '{32'd100,        ""},
        '{32'd4294967295, "4294967295"},
        '{32'd4294967294, ""},
        '{32'd1000000000, "1000000000"},
        '{32'd999999999,  "999999999"},
        '{32'd1000000001, ""},
        '{32'd2147483648, ""},
        '{32'h5555_5555,  ""},
        '{32'hAAAA_AAAA,  ""},
        '{32'd1234567890, "1234567890"},
        '{32'd4000000000, ""},
        '{32'd100000,     ""},
        '{32'd7,          ""},
        '{32'd0,          "0"},
        '{32'd0,          "0"},
        '{32'd3,          ""}
    };

    binary_to_decimal_ascii_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_value      (i_value),
        .empty        (empty),
        .pop          (pop),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // worst case is roughly 280 numbers of ten digits each waiting out the
    // longest pop gap, plus the two long holds; this is several times that
    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    // split a value into decimal digits, most significant first, leading
    // zeros dropped; zero still yields one '0' digit flagged last
    task automatic expect_decimal_text(input logic [bda_pkg::VALUE_BITS-1:0] value);
        logic [bda_pkg::DIGIT_W-1:0]    dec_digit [bda_pkg::MAX_DIGITS];
        logic [bda_pkg::VALUE_BITS-1:0] rest;
        int                             top;
        rest = value;
        top  = 0;
        for (int i = 0; i < bda_pkg::MAX_DIGITS; i++) begin
            dec_digit[i] = bda_pkg::DIGIT_W'(rest % DECIMAL_BASE);
            rest         = rest / DECIMAL_BASE;
            if (dec_digit[i] != '0) top = i;
        end
        for (int i = top; i >= 0; i--) begin
            pending_digits.push_back('{
                digit_char: bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(dec_digit[i]),
                is_last:    (i == 0)});
        end
    endtask

    // offer one number after an idle gap, hold until the block takes it,
    // then record the digits it owes; push stays high across back to back
    // transactions so it is never lowered and raised in one step
    task automatic push_value(input logic [bda_pkg::VALUE_BITS-1:0] value,
                              input string text, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        // accepted at this edge
        if (text.len() != 0) begin
            for (int i = 0; i < text.len(); i++) begin
                pending_digits.push_back('{digit_char: bda_pkg::CHAR_W'(text[i]),
                                           is_last: (i == text.len() - 1)});
            end
        end else begin
            expect_decimal_text(value);
        end
    endtask

    // sender goes quiet until every owed digit has come out
    task automatic drain_digits();
        push <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
    endtask

    // result side: random pop gaps, gapless stretches, and two long holds
    // that let the queue fill up and push back on the sender
    task automatic receive_digits();
        t_digit_txn want;
        int         gap;
        forever begin
            if (digits_received == 50 || digits_received == 700)
                gap = LONG_HOLD;
            else if ((digits_received / 300) % 3 == 1)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            // digit transaction taken at this edge
            digits_received++;
            if (pending_digits.size() == 0) begin
                $error("unexpected digit transaction: digit_char %0d last %0b",
                       o_digit_char, o_last);
                mismatch_count++;
            end else begin
                want = pending_digits.pop_front();
                if (o_digit_char !== want.digit_char) begin
                    $error("digit_char mismatch: expected %0d, actual %0d",
                           want.digit_char, o_digit_char);
                    mismatch_count++;
                end
                if (o_last !== want.is_last) begin
                    $error("last mismatch: expected %0b, actual %0b",
                           want.is_last, o_last);
                    mismatch_count++;
                end
            end
        end
    endtask

    initial begin
        logic [bda_pkg::VALUE_BITS-1:0] value;
        logic [bda_pkg::VALUE_BITS-1:0] decade;
        int                             kind;
        int                             gap;
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        pop     <= 1'b0;
        i_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            receive_digits();
        join_none

        foreach (number_rows[r])
            push_value(number_rows[r].value, number_rows[r].text,
                       $urandom_range(0, MAX_GAP));
        drain_digits();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // one pause with the block fully drained halfway through
            if (n == RANDOM_ITEMS / 2) drain_digits();
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                // spread over all digit counts
                value = $urandom >> $urandom_range(0, bda_pkg::VALUE_BITS - 1);
            end else if (kind <= 7) begin
                value = $urandom;
            end else if (kind == 8) begin
                value = $urandom_range(0, 20);
            end else begin
                // a power of ten or one either side of it
                decade = 1;
                repeat ($urandom_range(0, bda_pkg::MAX_DIGITS - 1))
                    decade = decade * DECIMAL_BASE;
                value = decade + $urandom_range(0, 2) - 1;
            end
            // back to back stretches next to randomly gapped ones
            if ((n >= 40 && n < 80) || (n >= 180 && n < 200))
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            push_value(value, "", gap);
        end

        drain_digits();
        // watch for stray digits past the converter latency
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
